FILE: hw/rtl/bounded_deque_with_eviction_macros.svh
// assertion macros for the bounded deque block
// included by files that carry concurrent checks; no other dependencies
`ifndef BOUNDED_DEQUE_WITH_EVICTION_MACROS_SVH
`define BOUNDED_DEQUE_WITH_EVICTION_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while reset is high
`define BDQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled while reset is high
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BDQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/bdq_pkg.sv
// types and constants shared by the bounded deque block
// no dependencies; compiled first
package bdq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int INDEX_W     = 4;
   localparam int CAP_W       = 5;
   localparam int CAP_RESET   = 16;
   localparam int CAP_CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int IDX_CMP_W   = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_PUSH   = 2'd1,
      KIND_POP    = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      kind_type               kind;
      logic [VALUE_WIDTH-1:0] value;
      logic [INDEX_W-1:0]     index;
   } op_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] taken_value;
      status_type             status;
      logic                   evicted;
      logic [CNT_W-1:0]       occupancy;
      logic                   is_empty;
   } result_type;

endpackage

FILE: hw/rtl/bdq_req_if.sv
// request channel of the bounded deque: valid/ready plus operation fields
// depends on bdq_pkg for field widths
interface bdq_req_if;
   import bdq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [VALUE_WIDTH-1:0] value;
   logic [INDEX_W-1:0]     index;

   modport source (output valid, output kind, output value, output index, input ready);
   modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

FILE: hw/rtl/bdq_rsp_if.sv
// response channel of the bounded deque: valid/ready plus result fields
// depends on bdq_pkg for field widths
interface bdq_rsp_if;
   import bdq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] taken_value;
   logic [STATUS_W-1:0]    status;
   logic                   evicted;
   logic [CNT_W-1:0]       occupancy;
   logic                   is_empty;

   modport source (output valid, output taken_value, output status, output evicted,
                   output occupancy, output is_empty, input ready);
   modport sink   (input valid, input taken_value, input status, input evicted,
                   input occupancy, input is_empty, output ready);
endinterface

FILE: hw/rtl/bdq_core.sv
// entry register array and count of the deque, with the per-request update logic
// depends on bdq_pkg; instantiated by bounded_deque_with_eviction
module bdq_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          op_fire,
   input  bdq_pkg::op_type               op,
   input  logic [bdq_pkg::CAP_W-1:0]     capacity,
   output bdq_pkg::result_type           result
);
   import bdq_pkg::*;

   logic [VALUE_WIDTH-1:0] entries_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] entries_in [DEPTH];
   logic [VALUE_WIDTH-1:0] shl        [DEPTH];
   logic [VALUE_WIDTH-1:0] shr        [DEPTH];
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CNT_W-1:0]       count_dec;
   logic [CAP_CMP_W-1:0]   cap_ext;
   logic [CAP_CMP_W-1:0]   eff_cap;
   logic                   full;
   logic                   empty;
   logic                   index_bad;
   logic [IDX_W-1:0]       read_sel;
   logic [VALUE_WIDTH-1:0] taken_raw;

   // neighbor views of the array for the shifting operations
   for (genvar g = 0; g < DEPTH; g++) begin : g_shift
      if (g < DEPTH - 1) begin : g_shl
         assign shl[g] = entries_ff[g+1];
      end else begin : g_shl_last
         assign shl[g] = entries_ff[g];
      end
      if (g == 0) begin : g_shr_first
         assign shr[g] = op.value;
      end else begin : g_shr
         assign shr[g] = entries_ff[g-1];
      end
   end

   always_comb begin
      cap_ext = CAP_CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CAP_CMP_W'(1);
      end else if (cap_ext > CAP_CMP_W'(DEPTH)) begin
         eff_cap = CAP_CMP_W'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign empty     = (count_ff == '0);
   assign full      = !empty && (CAP_CMP_W'(count_ff) >= eff_cap);
   assign count_dec = count_ff - CNT_W'(1);
   assign index_bad = IDX_CMP_W'(op.index) >= IDX_CMP_W'(count_ff);
   assign read_sel  = (op.kind == KIND_POP) ? IDX_W'(count_dec) : IDX_W'(op.index);
   assign taken_raw = entries_ff[read_sel];

   always_comb begin
      entries_in         = entries_ff;
      count_in           = count_ff;
      result.taken_value = '0;
      result.status      = STATUS_OK;
      result.evicted     = 1'b0;
      unique case (op.kind)
         KIND_APPEND: begin
            result.evicted = full;
            for (int i = 0; i < DEPTH; i++) begin
               if (full) begin
                  entries_in[i] = (CNT_W'(i) == count_dec) ? op.value : shl[i];
               end else if (CNT_W'(i) == count_ff) begin
                  entries_in[i] = op.value;
               end
            end
            if (!full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_PUSH: begin
            result.evicted = full;
            entries_in     = shr;
            if (!full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_POP: begin
            if (empty) begin
               result.status = STATUS_EMPTY;
            end else begin
               result.taken_value = taken_raw;
               count_in           = count_dec;
            end
         end
         KIND_REMOVE: begin
            if (empty) begin
               result.status = STATUS_EMPTY;
            end else if (index_bad) begin
               result.status = STATUS_RANGE;
            end else begin
               result.taken_value = taken_raw;
               count_in           = count_dec;
               for (int i = 0; i < DEPTH; i++) begin
                  if (IDX_W'(i) >= read_sel) begin
                     entries_in[i] = shl[i];
                  end
               end
            end
         end
      endcase
      result.occupancy = count_in;
      result.is_empty  = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (op_fire) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_fire) begin
         entries_ff <= entries_in;
      end
   end

endmodule

FILE: hw/rtl/bounded_deque_with_eviction.sv
// bounded double-ended queue with eviction: top level
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_core and the macro header
//
// usage:
//   req_ch carries one request per valid/ready handshake: kind selects append at
//   the back, push at the front, pop from the back or remove at index; value is
//   the data to insert, index the position from the front for remove.
//   rsp_ch returns exactly one response per request, in order: the value taken,
//   a status (ok, empty, index out of range), the eviction flag, the occupancy
//   after the request and an empty flag.
//   csr_write_enable/csr_write_data set the capacity (0 acts as 1, values above
//   the depth act as the depth); write it only while no request is in flight.
// pipeline and throughput:
//   a request accepted into the input register is applied to the entry array and
//   its result is registered in the output register once that register is free;
//   the response is valid from then on until it is taken. One request per cycle
//   is sustained while rsp_ch.ready stays high.
// reset and stalls:
//   reset empties the store, sets capacity to its maximum and drops anything in
//   flight. While rsp_ch.ready is low the response holds, one more request is
//   taken if the input register is empty, and then req_ch.ready falls.
`include "bounded_deque_with_eviction_macros.svh"

module bounded_deque_with_eviction (
   input  logic                          clock,
   input  logic                          reset,
   bdq_req_if.sink                       req_ch,
   bdq_rsp_if.source                     rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [bdq_pkg::CAP_W-1:0]     csr_write_data
);
   import bdq_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic             in_valid_ff;
   logic             in_valid_in;
   op_type           in_op_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   result_type       out_res_ff;
   result_type       core_result;
   logic             out_free;
   logic             advance;
   logic             accept;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RESET);
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   // input and output stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff.kind  <= kind_type'(req_ch.kind);
         in_op_ff.value <= req_ch.value;
         in_op_ff.index <= req_ch.index;
      end
      if (advance) begin
         out_res_ff <= core_result;
      end
   end

   bdq_core u_core (
      .clock    (clock),
      .reset    (reset),
      .op_fire  (advance),
      .op       (in_op_ff),
      .capacity (capacity_ff),
      .result   (core_result)
   );

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.taken_value = out_res_ff.taken_value;
   assign rsp_ch.status      = out_res_ff.status;
   assign rsp_ch.evicted     = out_res_ff.evicted;
   assign rsp_ch.occupancy   = out_res_ff.occupancy;
   assign rsp_ch.is_empty    = out_res_ff.is_empty;

   `BDQ_ASSERT_IMPLY(a_empty_flag, clock, reset, rsp_ch.valid, rsp_ch.is_empty == (rsp_ch.occupancy == '0), "empty flag disagrees with occupancy")
   `BDQ_ASSERT_IMPLY(a_taken_zero, clock, reset, rsp_ch.valid && (rsp_ch.evicted || rsp_ch.status != STATUS_OK), rsp_ch.taken_value == '0, "nonzero value on insert or error")
   `BDQ_ASSERT_IMPLY(a_occ_bound, clock, reset, rsp_ch.valid, rsp_ch.occupancy <= CNT_W'(DEPTH), "occupancy beyond depth")
   `BDQ_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !out_free, in_valid_ff, "stalled request lost from input stage")

endmodule
